/* hw/rtl/tmpw_pkg.sv */
// Shared types, constants and helper functions for the tile map pixel writer.
// Used by tmpw_emit and tile_map_pixel_writer; depends on nothing else.
`default_nettype none

package tmpw_pkg;

	localparam int TILES_ACROSS = 28;
	localparam int TILES_DOWN   = 36;
	localparam int CLIP_ROWS    = 480;
	localparam int TILE_PX      = 8;

	localparam int CFG_W   = 11;
	localparam int COORD_W = 12;
	localparam int ROW_W   = $clog2(CLIP_ROWS);
	localparam int ADDR_W  = 19;
	localparam int RGBA_W  = 32;
	localparam int PROD_W  = ROW_W + CFG_W;
	localparam int POS_W   = 6;
	localparam int SUB_W   = 3;
	localparam int NIB_W   = 4;
	localparam int COLORS  = 16;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);

	typedef enum logic {
		OP_RENDER  = 1'b0,
		OP_PALETTE = 1'b1
	} op_t;

	typedef enum logic {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	localparam logic [RGBA_W-1:0] DEFAULT_COLORS [COLORS] = '{
		32'h000000FF, 32'hFF0000FF, 32'hFFB897FF, 32'hFFB8FFFF,
		32'h00FFFFFF, 32'hFFB800FF, 32'h51FFFFFF, 32'hFFFF00FF,
		32'hFFB897FF, 32'hFFB800FF, 32'hFFFFFFFF, 32'h0000FFFF,
		32'h00FF00FF, 32'hFFFFB8FF, 32'hFF00FFFF, 32'hFFB851FF
	};

	// One scanned pixel position as it enters the output stage.
	typedef struct packed {
		logic              keep;
		logic              tile_end;
		logic [PROD_W-1:0] prod;
		logic [CFG_W-1:0]  sx;
		logic [RGBA_W-1:0] rgba;
	} pix_t;

	// Half of (extent - span), truncated toward zero.
	function automatic logic signed [COORD_W-1:0] center_offset(
		input logic [CFG_W-1:0]   extent,
		input logic [COORD_W-1:0] span
	);
		logic signed [COORD_W-1:0] diff;
		logic signed [COORD_W-1:0] rounded;
		diff    = $signed({1'b0, extent}) - $signed(span);
		rounded = diff + $signed({{(COORD_W-1){1'b0}}, diff[COORD_W-1]});
		return rounded >>> 1;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/tmpw_emit.sv */
// Output stage of the tile map pixel writer: holds back one drawn pixel to mark the last one.
// Depends on tmpw_pkg.
`default_nettype none

module tmpw_emit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s3_valid,
	input  wire tmpw_pkg::pix_t              s3,
	output logic                             adv,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [tmpw_pkg::ADDR_W-1:0]      pixel_address,
	output logic [tmpw_pkg::RGBA_W-1:0]      pixel_rgba,
	output logic                             last_pixel
);

	logic                          pend_v_q;
	logic                          pend_close_q;
	logic [tmpw_pkg::ADDR_W-1:0]   pend_addr_q;
	logic [tmpw_pkg::RGBA_W-1:0]   pend_rgba_q;
	logic [tmpw_pkg::PROD_W-1:0]   addr_sum;
	logic [tmpw_pkg::ADDR_W-1:0]   new_addr;
	logic                          emit;
	logic                          emit_last;
	logic                          take_new;

	assign adv       = !out_valid || out_ready;
	assign addr_sum  = s3.prod + {{(tmpw_pkg::PROD_W-tmpw_pkg::CFG_W){1'b0}}, s3.sx};
	assign new_addr  = addr_sum[tmpw_pkg::ADDR_W-1:0];
	assign take_new  = s3_valid && s3.keep;
	assign emit      = pend_v_q && (pend_close_q || (s3_valid && (s3.keep || s3.tile_end)));
	assign emit_last = pend_close_q || !take_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			pend_v_q     <= 1'b0;
			pend_close_q <= 1'b0;
		end else if (adv) begin
			out_valid <= emit;
			if (take_new) begin
				pend_v_q     <= 1'b1;
				pend_close_q <= s3.tile_end;
			end else if (emit) begin
				pend_v_q     <= 1'b0;
				pend_close_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (emit) begin
				pixel_address <= pend_addr_q;
				pixel_rgba    <= pend_rgba_q;
				last_pixel    <= emit_last;
			end
			if (take_new) begin
				pend_addr_q <= new_addr;
				pend_rgba_q <= s3.rgba;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/tile_map_pixel_writer.sv */
// Tile map pixel writer: 8x8 tile scanner, clip and address pipeline, palette registers.
// Depends on tmpw_pkg and tmpw_emit.
// The scanner issues one pixel position of a render item per cycle unless the output stalls.
// A palette write updates its entry when accepted. A drawn pixel passes s1, s2, s3 and the
// pending register and moves to the output register once the next drawn pixel or tile end catches up.
// Output stalls freeze the pipeline. Reset empties it, sets 640x480 and loads the default palette.
`default_nettype none

module tile_map_pixel_writer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write,
	input  wire logic                         cfg_index,
	input  wire logic [tmpw_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         op,
	input  wire logic [4:0]                   tile_column,
	input  wire logic [5:0]                   tile_row,
	input  wire logic [7:0]                   tile_code,
	input  wire logic [7:0]                   palette_select,
	input  wire logic [3:0]                   entry_index,
	input  wire logic [tmpw_pkg::RGBA_W-1:0]  entry_rgba,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [tmpw_pkg::ADDR_W-1:0]       pixel_address,
	output logic [tmpw_pkg::RGBA_W-1:0]       pixel_rgba,
	output logic                              last_pixel
);

	localparam int CW = tmpw_pkg::COORD_W;

	logic [tmpw_pkg::CFG_W-1:0]   fw_q;
	logic [tmpw_pkg::CFG_W-1:0]   fh_q;
	logic [tmpw_pkg::RGBA_W-1:0]  color_q [tmpw_pkg::COLORS];

	logic                         busy_q;
	logic [tmpw_pkg::POS_W-1:0]   pos_q;
	logic [tmpw_pkg::NIB_W-1:0]   nib_q;
	logic [tmpw_pkg::RGBA_W-1:0]  rgba_q;
	logic signed [CW-1:0]         bx_q;
	logic signed [CW-1:0]         by_q;

	logic                         v_s1;
	logic                         draw_s1;
	logic                         end_s1;
	logic signed [CW-1:0]         sx_s1;
	logic signed [CW-1:0]         sy_s1;
	logic [tmpw_pkg::RGBA_W-1:0]  rgba_s1;

	logic                         v_s2;
	logic                         keep_s2;
	logic                         end_s2;
	logic [tmpw_pkg::CFG_W-1:0]   sx_s2;
	logic [tmpw_pkg::ROW_W-1:0]   sy_s2;
	logic [tmpw_pkg::RGBA_W-1:0]  rgba_s2;

	logic                         v_s3;
	logic                         keep_s3;
	logic                         end_s3;
	logic [tmpw_pkg::PROD_W-1:0]  prod_s3;
	logic [tmpw_pkg::CFG_W-1:0]   sx_s3;
	logic [tmpw_pkg::RGBA_W-1:0]  rgba_s3;

	logic                         adv;
	logic                         in_fire;
	logic                         is_render;
	logic                         scan_last;
	logic signed [CW-1:0]         base_x;
	logic signed [CW-1:0]         base_y;
	logic                         draw_next;
	logic signed [CW-1:0]         sx_next;
	logic signed [CW-1:0]         sy_next;
	logic                         keep_next;
	tmpw_pkg::pix_t               pix_s3;

	assign scan_last = &pos_q;
	assign in_ready  = !busy_q || (adv && scan_last);
	assign in_fire   = in_valid && in_ready;
	assign is_render = tmpw_pkg::op_t'(op) == tmpw_pkg::OP_RENDER;

	assign base_x = tmpw_pkg::center_offset(fw_q, CW'(tmpw_pkg::TILES_ACROSS * tmpw_pkg::TILE_PX))
		+ $signed({{(CW-8){1'b0}}, tile_column, 3'b000});
	assign base_y = tmpw_pkg::center_offset(fh_q, CW'(tmpw_pkg::TILES_DOWN * tmpw_pkg::TILE_PX))
		+ $signed({{(CW-9){1'b0}}, tile_row, 3'b000});

	// The reset tile graphics are a checkerboard of the code's low nibble.
	assign draw_next = (nib_q != '0) && (pos_q[0] ^ pos_q[3] ^ nib_q[0]);
	assign sx_next   = bx_q + $signed({{(CW-tmpw_pkg::SUB_W){1'b0}}, pos_q[2:0]});
	assign sy_next   = by_q + $signed({{(CW-tmpw_pkg::SUB_W){1'b0}}, pos_q[5:3]});

	assign keep_next = draw_s1 && !sx_s1[CW-1] && !sy_s1[CW-1]
		&& ($unsigned(sx_s1) < {1'b0, fw_q})
		&& ($unsigned(sy_s1) < CW'(tmpw_pkg::CLIP_ROWS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= tmpw_pkg::FRAME_WIDTH_RESET;
			fh_q <= tmpw_pkg::FRAME_HEIGHT_RESET;
		end else if (cfg_write) begin
			case (tmpw_pkg::cfg_idx_t'(cfg_index))
				tmpw_pkg::CFG_FRAME_WIDTH:  fw_q <= cfg_data;
				tmpw_pkg::CFG_FRAME_HEIGHT: fh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tmpw_pkg::COLORS; i++) begin
				color_q[i] <= tmpw_pkg::DEFAULT_COLORS[i];
			end
		end else if (in_fire && !is_render) begin
			color_q[entry_index] <= entry_rgba;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			if (in_fire && is_render) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (adv && busy_q) begin
				pos_q <= pos_q + 1'b1;
				if (scan_last) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				v_s1 <= busy_q;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && is_render) begin
			nib_q  <= tile_code[3:0];
			rgba_q <= color_q[palette_select[3:0]];
			bx_q   <= base_x;
			by_q   <= base_y;
		end
		if (adv) begin
			draw_s1 <= draw_next;
			end_s1  <= scan_last;
			sx_s1   <= sx_next;
			sy_s1   <= sy_next;
			rgba_s1 <= rgba_q;

			keep_s2 <= keep_next;
			end_s2  <= end_s1;
			sx_s2   <= sx_s1[tmpw_pkg::CFG_W-1:0];
			sy_s2   <= sy_s1[tmpw_pkg::ROW_W-1:0];
			rgba_s2 <= rgba_s1;

			keep_s3 <= keep_s2;
			end_s3  <= end_s2;
			prod_s3 <= tmpw_pkg::PROD_W'(sy_s2) * tmpw_pkg::PROD_W'(fw_q);
			sx_s3   <= sx_s2;
			rgba_s3 <= rgba_s2;
		end
	end

	always_comb begin
		pix_s3.keep     = keep_s3;
		pix_s3.tile_end = end_s3;
		pix_s3.prod     = prod_s3;
		pix_s3.sx       = sx_s3;
		pix_s3.rgba     = rgba_s3;
	end

	tmpw_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.s3_valid      (v_s3),
		.s3            (pix_s3),
		.adv           (adv),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_address (pixel_address),
		.pixel_rgba    (pixel_rgba),
		.last_pixel    (last_pixel)
	);

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for tile_map_pixel_writer: directed and random tile and palette traffic
// with a pixel predictor, bursty input, output stalls and a long output hold-off.
// Depends on tmpw_pkg and the tile_map_pixel_writer RTL only.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		tmpw_pkg::op_t op;
		logic [4:0]    col;
		logic [5:0]    row;
		logic [7:0]    code;
		logic [7:0]    color;
		logic [3:0]    entry;
		logic [31:0]   rgba;
	} tile_item_t;

	typedef struct packed {
		logic [tmpw_pkg::ADDR_W-1:0] addr;
		logic [tmpw_pkg::RGBA_W-1:0] rgba;
		logic                        is_last;
	} drawn_px_t;

	typedef enum int {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_PATTERN} rx_mode_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_write = 1'b0;
	tmpw_pkg::cfg_idx_t          cfg_index = tmpw_pkg::CFG_FRAME_WIDTH;
	logic [tmpw_pkg::CFG_W-1:0]  cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	tmpw_pkg::op_t               op = tmpw_pkg::OP_RENDER;
	logic [4:0]                  tile_column = '0;
	logic [5:0]                  tile_row = '0;
	logic [7:0]                  tile_code = '0;
	logic [7:0]                  palette_select = '0;
	logic [3:0]                  entry_index = '0;
	logic [tmpw_pkg::RGBA_W-1:0] entry_rgba = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [tmpw_pkg::ADDR_W-1:0] pixel_address;
	logic [tmpw_pkg::RGBA_W-1:0] pixel_rgba;
	logic                        last_pixel;

	drawn_px_t                   expected_pixels[$];
	drawn_px_t                   front_px;
	logic [tmpw_pkg::RGBA_W-1:0] palette_model [tmpw_pkg::COLORS];
	logic [tmpw_pkg::CFG_W-1:0]  frame_w = tmpw_pkg::FRAME_WIDTH_RESET;
	logic [tmpw_pkg::CFG_W-1:0]  frame_h = tmpw_pkg::FRAME_HEIGHT_RESET;
	int                          mismatches = 0;
	int unsigned                 cycle_count = 0;
	int                          burst_left = 0;
	int                          hold_cycles = 0;
	int                          rx_phase = 0;
	rx_mode_t                    rx_mode = RX_STREAM;
	logic [15:0]                 rx_pattern = '1;

	tile_map_pixel_writer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.tile_column(tile_column),
		.tile_row(tile_row),
		.tile_code(tile_code),
		.palette_select(palette_select),
		.entry_index(entry_index),
		.entry_rgba(entry_rgba),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_address(pixel_address),
		.pixel_rgba(pixel_rgba),
		.last_pixel(last_pixel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t ns mismatch: %s", $time, msg);
	endtask

	// Queues the pixels that one rendered tile should produce, in scan order.
	function automatic void predict_tile(input logic [4:0] col, input logic [5:0] row,
			input logic [7:0] code, input logic [7:0] color);
		int        xoff;
		int        yoff;
		int        sx;
		int        sy;
		int        lin;
		logic [3:0] nib;
		drawn_px_t pending;
		bit        have_pending;
		have_pending = 0;
		pending = '0;
		xoff = (int'(frame_w) - tmpw_pkg::TILES_ACROSS * tmpw_pkg::TILE_PX) / 2;
		yoff = (int'(frame_h) - tmpw_pkg::TILES_DOWN * tmpw_pkg::TILE_PX) / 2;
		for (int py = 0; py < tmpw_pkg::TILE_PX; py++) begin
			for (int px = 0; px < tmpw_pkg::TILE_PX; px++) begin
				nib = ((px + py + int'(code)) % 2 == 1) ? code[3:0] : 4'h0;
				sx = xoff + int'(col) * tmpw_pkg::TILE_PX + px;
				sy = yoff + int'(row) * tmpw_pkg::TILE_PX + py;
				if (nib != 4'h0 && sx >= 0 && sy >= 0 && sx < int'(frame_w)
						&& sy < tmpw_pkg::CLIP_ROWS) begin
					if (have_pending)
						expected_pixels.push_back(pending);
					lin = sy * int'(frame_w) + sx;
					pending.addr = lin[tmpw_pkg::ADDR_W-1:0];
					pending.rgba = palette_model[color[3:0]];
					pending.is_last = 1'b0;
					have_pending = 1;
				end
			end
		end
		if (have_pending) begin
			pending.is_last = 1'b1;
			expected_pixels.push_back(pending);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			if (op == tmpw_pkg::OP_PALETTE)
				palette_model[entry_index] = entry_rgba;
			else
				predict_tile(tile_column, tile_row, tile_code, palette_select);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel at address %0d", pixel_address));
			end else begin
				front_px = expected_pixels.pop_front();
				if (pixel_address !== front_px.addr)
					report_mismatch($sformatf("pixel_address %0d, expected %0d",
						pixel_address, front_px.addr));
				if (pixel_rgba !== front_px.rgba)
					report_mismatch($sformatf("pixel_rgba %08h, expected %08h at address %0d",
						pixel_rgba, front_px.rgba, front_px.addr));
				if (last_pixel !== front_px.is_last)
					report_mismatch($sformatf("last_pixel %b, expected %b at address %0d",
						last_pixel, front_px.is_last, front_px.addr));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else begin
			if (rx_phase == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_pattern = 16'($urandom);
				rx_phase = $urandom_range(16, 96);
			end
			rx_phase--;
			case (rx_mode)
				RX_STREAM: out_ready <= 1'b1;
				RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= rx_pattern[rx_phase % 16];
			endcase
		end
	end

	task automatic send_item(input tile_item_t it);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(20, 90);
				default: gap = $urandom_range(1, 12);
			endcase
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op;
		tile_column <= it.col;
		tile_row <= it.row;
		tile_code <= it.code;
		palette_select <= it.color;
		entry_index <= it.entry;
		entry_rgba <= it.rgba;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic render(input logic [4:0] col, input logic [5:0] row,
			input logic [7:0] code, input logic [7:0] color);
		tile_item_t it;
		it = {tmpw_pkg::OP_RENDER, col, row, code, color, 4'($urandom), 32'($urandom)};
		send_item(it);
	endtask

	task automatic write_palette(input logic [3:0] entry, input logic [31:0] rgba);
		tile_item_t it;
		it = {tmpw_pkg::OP_PALETTE, 5'($urandom), 6'($urandom), 8'($urandom), 8'($urandom),
			entry, rgba};
		send_item(it);
	endtask

	function automatic tile_item_t random_item();
		tile_item_t it;
		it.op = ($urandom_range(0, 99) < 15) ? tmpw_pkg::OP_PALETTE : tmpw_pkg::OP_RENDER;
		if ($urandom_range(0, 4) == 0) begin
			it.col = 5'($urandom);
			it.row = 6'($urandom);
		end else begin
			it.col = 5'($urandom_range(0, tmpw_pkg::TILES_ACROSS - 1));
			it.row = 6'($urandom_range(0, tmpw_pkg::TILES_DOWN - 1));
		end
		it.code = 8'($urandom);
		it.color = 8'($urandom);
		it.entry = 4'($urandom);
		it.rgba = $urandom;
		return it;
	endfunction

	// The first edge lets the predictor take in the last transfer before the queue is checked.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_frame(input logic [tmpw_pkg::CFG_W-1:0] w,
			input logic [tmpw_pkg::CFG_W-1:0] h);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= tmpw_pkg::CFG_FRAME_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= tmpw_pkg::CFG_FRAME_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_write <= 1'b0;
		frame_w = w;
		frame_h = h;
	endtask

	task automatic test_reset_geometry();
		render(5'd0, 6'd0, 8'h01, 8'h00);
		render(5'd27, 6'd35, 8'h0F, 8'hFF);
		render(5'd31, 6'd63, 8'hFF, 8'h03);
		render(5'd31, 6'd0, 8'hFE, 8'h80);
		render(5'd5, 6'd5, 8'h00, 8'h11);
		render(5'd5, 6'd6, 8'h10, 8'h22);
	endtask

	task automatic test_palette_writes();
		write_palette(4'd0, 32'hFFFFFFFF);
		write_palette(4'd15, 32'h00000000);
		write_palette(4'd10, 32'h12345678);
		render(5'd3, 6'd4, 8'h0B, 8'hF0);
		render(5'd4, 6'd4, 8'h0C, 8'h0F);
		render(5'd6, 6'd7, 8'h31, 8'h1A);
	endtask

	task automatic test_frame_extremes();
		set_frame(11'd224, 11'd288);
		render(5'd0, 6'd0, 8'h07, 8'h01);
		render(5'd27, 6'd35, 8'h09, 8'h02);
		render(5'd28, 6'd36, 8'h05, 8'h04);
		set_frame(11'd1024, 11'd1024);
		render(5'd0, 6'd0, 8'h03, 8'h05);
		render(5'd27, 6'd13, 8'h0D, 8'h06);
		render(5'd31, 6'd14, 8'h0E, 8'h07);
		set_frame(11'd2047, 11'd2047);
		render(5'd31, 6'd30, 8'hF5, 8'h08);
		render(5'd0, 6'd0, 8'h06, 8'h09);
		render(5'd20, 6'd63, 8'h0A, 8'h0C);
		set_frame(11'd200, 11'd100);
		render(5'd0, 6'd11, 8'h0F, 8'h0D);
		render(5'd1, 6'd12, 8'h04, 8'h0E);
		render(5'd26, 6'd63, 8'h02, 8'h0B);
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_frame(tmpw_pkg::FRAME_WIDTH_RESET, tmpw_pkg::FRAME_HEIGHT_RESET);
				3: set_frame(11'($urandom), 11'($urandom));
				default: set_frame(11'($urandom_range(224, 1024)),
					11'($urandom_range(288, 1024)));
			endcase
			for (int n = 0; n < 46; n++)
				send_item(random_item());
		end
	endtask

	// The output is held off while tiles keep coming, so the pipeline fills and
	// the input side has to stall.
	task automatic test_backpressure();
		set_frame(11'd640, 11'd480);
		@(posedge clk);
		hold_cycles = 600;
		burst_left = 16;
		for (int n = 0; n < 16; n++)
			render(5'($urandom_range(0, tmpw_pkg::TILES_ACROSS - 1)),
				6'($urandom_range(0, tmpw_pkg::TILES_DOWN - 1)),
				8'({4'($urandom), 4'($urandom_range(1, 15))}), 8'($urandom));
	endtask

	initial begin
		palette_model = tmpw_pkg::DEFAULT_COLORS;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_palette_writes();
		test_frame_extremes();
		test_random_traffic();
		test_backpressure();
		wait_idle();
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
